@@ rtl/coalescing_range_set_defines.svh @@
// Assertion macros for the coalescing range set.
// Included by the top level; depends on nothing else.
`ifndef COALESCING_RANGE_SET_DEFINES_SVH
`define COALESCING_RANGE_SET_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("coalescing_range_set: check failed");

// Next-cycle implication, disabled during reset.
`define CRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("coalescing_range_set: check failed");

`endif

@@ rtl/crs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes of the coalescing range set.
// No dependencies.
package crs_pkg;

    localparam int OP_BITS     = 3;
    localparam int STATUS_BITS = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD        = 3'd0,
        OP_REMOVE     = 3'd1,
        OP_COVERS     = 3'd2,
        OP_INTERSECTS = 3'd3,
        OP_FIND       = 3'd4,
        OP_CLEAR      = 3'd5
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        STS_OK        = 2'd0,
        STS_BAD_RANGE = 2'd1,
        STS_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    // Per-cell update commands, broadcast along the row.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ABSORB,
        CELL_MERGE,
        CELL_SPLIT,
        CELL_TRIM_HI,
        CELL_TRIM_LO,
        CELL_DELETE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     add_mode;   // select add (touching) flags, else remove flags
    } t_cell_cmd;

    typedef struct packed {
        logic b_add;      // entirely below, not touching
        logic b_rem;      // entirely below
        logic o_add;      // overlaps or touches
        logic o_rem;      // overlaps
        logic first_add;
        logic first_rem;
        logic first_sel;  // first of the mode's overlap run
        logic nxt_sel;    // right after first_sel
        logic multi;      // first_add and neighbor also touches
        logic cov;
        logic isect;
        logic cont;
    } t_cell_flags;

    // Left neighbor of cell 0: everything "before" it.
    localparam t_cell_flags CELL_EDGE_LEFT = '{b_add: 1'b1, default: 1'b0};

    typedef struct packed {
        logic any_o_add;
        logic any_o_rem;
        logic multi;
        logic cov;
        logic isect;
        logic cont;
    } t_chain_status;

endpackage

@@ rtl/crs_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the coalescing range set.
// Depends on crs_pkg.
interface crs_in_if #(parameter int ADDR_BITS = 32) ();
    logic                         valid;
    logic                         ready;
    logic [crs_pkg::OP_BITS-1:0]  op;
    logic [ADDR_BITS-1:0]         range_start;
    logic [ADDR_BITS-1:0]         range_end;

    modport source(output valid, op, range_start, range_end, input ready);
    modport sink(input valid, op, range_start, range_end, output ready);
endinterface

interface crs_out_if #(parameter int ADDR_BITS = 32, parameter int CNT_BITS = 7) ();
    logic                            valid;
    logic                            ready;
    logic [crs_pkg::STATUS_BITS-1:0] status;
    logic                            hit;
    logic [ADDR_BITS-1:0]            found_start;
    logic [ADDR_BITS-1:0]            found_end;
    logic [CNT_BITS-1:0]             ranges_held;
    logic [ADDR_BITS:0]              addresses_held;

    modport source(output valid, status, hit, found_start, found_end, ranges_held,
                   addresses_held, input ready);
    modport sink(input valid, status, hit, found_start, found_end, ranges_held,
                 addresses_held, output ready);
endinterface

@@ rtl/coalescing_range_set.sv @@
`timescale 1ns / 1ps
// Coalescing range set: sequencer, counters and result register.
// Depends on crs_pkg, crs_if, crs_chain and coalescing_range_set_defines.svh.
//
// Usage: commands arrive on i_in (op, range_start, range_end) and one result
// per command leaves on o_out. A transfer happens when valid and ready are
// both high at a rising edge of i_clk.
// The ranges live sorted in a row of MAX_RANGES cells. Each cell compares its
// range with the operand in parallel; the sequencer then issues one row
// command a cycle (insert, absorb a neighbor, merge, split, trim, delete).
// Queries, clear, bad ranges and full refusals take one step. Add takes one
// step per stored range it swallows beyond the first, plus one. Remove takes
// one step per range it deletes or trims, plus a closing step unless it ends
// by splitting a range or trimming its low end; at most MAX_RANGES + 1 steps.
// The delete loop over the cell row sets this worst case.
// One command is in flight at a time: i_in.ready is high only when the
// sequencer is idle, which is also while a finished result sits in the
// output register waiting for the receiver. If the receiver stalls, the next
// command is still processed and then waits until the output register frees.
// Reset (i_rst_n low, synchronous) empties the table and clears the count of
// covered addresses; the cells' contents need no clearing.
`include "coalescing_range_set_defines.svh"
module coalescing_range_set #(
    parameter int MAX_RANGES = 64,
    parameter int ADDR_BITS  = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    crs_in_if.sink           i_in,
    crs_out_if.source        o_out
);

    localparam int CNT_BITS = $clog2(MAX_RANGES + 1);
    localparam int W1       = ADDR_BITS + 1;

    crs_pkg::t_state r_state, n_state;

    // Operand latched at input transfer
    logic [crs_pkg::OP_BITS-1:0] r_op;
    logic [ADDR_BITS-1:0]        r_s, r_e;

    // Table bookkeeping
    logic [CNT_BITS-1:0] r_count, n_count;
    logic [W1-1:0]       r_total, n_total;

    // Result of the current command, waiting for the output register
    crs_pkg::t_status     r_res_status, n_res_status;
    logic                 r_res_hit, n_res_hit;
    logic [ADDR_BITS-1:0] r_res_fs, n_res_fs, r_res_fe, n_res_fe;

    // Output register
    logic                 r_out_valid, n_out_valid;
    logic                 w_load_out;
    crs_pkg::t_status     r_out_status;
    logic                 r_out_hit;
    logic [ADDR_BITS-1:0] r_out_fs, r_out_fe;
    logic [CNT_BITS-1:0]  r_out_count;
    logic [W1-1:0]        r_out_total;

    crs_pkg::t_cell_cmd     w_cmd;
    crs_pkg::t_chain_status w_cs;
    logic [ADDR_BITS-1:0]   w_sel_lo, w_sel_hi, w_nxt_lo, w_found_lo, w_found_hi;

    logic          w_accept, w_full;
    logic [W1-1:0] w_s_x, w_e_x, w_lo_x, w_hi_x, w_nxt_x, w_nl_x, w_nh_x;

    assign w_accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == crs_pkg::ST_IDLE);
    assign w_full     = (r_count == CNT_BITS'(MAX_RANGES));

    assign w_s_x   = {1'b0, r_s};
    assign w_e_x   = {1'b0, r_e};
    assign w_lo_x  = {1'b0, w_sel_lo};
    assign w_hi_x  = {1'b0, w_sel_hi};
    assign w_nxt_x = {1'b0, w_nxt_lo};
    assign w_nl_x  = (w_lo_x < w_s_x) ? w_lo_x : w_s_x;
    assign w_nh_x  = (w_hi_x > w_e_x) ? w_hi_x : w_e_x;

    crs_chain #(
        .MAX_RANGES(MAX_RANGES),
        .ADDR_BITS (ADDR_BITS),
        .CNT_BITS  (CNT_BITS)
    ) u_chain (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_s       (r_s),
        .i_e       (r_e),
        .i_count   (r_count),
        .o_status  (w_cs),
        .o_sel_lo  (w_sel_lo),
        .o_sel_hi  (w_sel_hi),
        .o_nxt_lo  (w_nxt_lo),
        .o_found_lo(w_found_lo),
        .o_found_hi(w_found_hi)
    );

    // Sequencer: one row command per cycle while running
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_total      = r_total;
        n_res_status = r_res_status;
        n_res_hit    = r_res_hit;
        n_res_fs     = r_res_fs;
        n_res_fe     = r_res_fe;
        w_cmd.op       = crs_pkg::CELL_HOLD;
        w_cmd.add_mode = (r_op == crs_pkg::OP_ADD);
        w_load_out   = 1'b0;

        unique case (r_state)
            crs_pkg::ST_IDLE: begin
                if (w_accept) n_state = crs_pkg::ST_RUN;
            end
            crs_pkg::ST_RUN: begin
                n_res_status = crs_pkg::STS_OK;
                n_res_hit    = 1'b0;
                n_res_fs     = '0;
                n_res_fe     = '0;
                n_state      = crs_pkg::ST_DONE;
                if ((r_op == crs_pkg::OP_ADD || r_op == crs_pkg::OP_REMOVE ||
                     r_op == crs_pkg::OP_COVERS || r_op == crs_pkg::OP_INTERSECTS) &&
                    (r_s > r_e)) begin
                    n_res_status = crs_pkg::STS_BAD_RANGE;
                end else begin
                    case (r_op)
                        crs_pkg::OP_ADD: begin
                            if (!w_cs.any_o_add) begin
                                if (w_full) begin
                                    n_res_status = crs_pkg::STS_FULL;
                                end else begin
                                    w_cmd.op = crs_pkg::CELL_INSERT;
                                    n_count  = r_count + CNT_BITS'(1);
                                    n_total  = r_total + (w_e_x - w_s_x) + W1'(1);
                                end
                            end else if (w_cs.multi) begin
                                // swallow the right neighbor and the gap before it
                                w_cmd.op = crs_pkg::CELL_ABSORB;
                                n_count  = r_count - CNT_BITS'(1);
                                n_total  = r_total + (w_nxt_x - w_hi_x) - W1'(1);
                                n_state  = crs_pkg::ST_RUN;
                            end else begin
                                w_cmd.op = crs_pkg::CELL_MERGE;
                                n_total  = r_total + (w_nh_x - w_nl_x) - (w_hi_x - w_lo_x);
                            end
                        end
                        crs_pkg::OP_REMOVE: begin
                            if (w_cs.any_o_rem) begin
                                if (w_lo_x < w_s_x && w_hi_x > w_e_x) begin
                                    if (w_full) begin
                                        n_res_status = crs_pkg::STS_FULL;
                                    end else begin
                                        w_cmd.op = crs_pkg::CELL_SPLIT;
                                        n_count  = r_count + CNT_BITS'(1);
                                        n_total  = r_total - (w_e_x - w_s_x) - W1'(1);
                                    end
                                end else if (w_lo_x < w_s_x) begin
                                    w_cmd.op = crs_pkg::CELL_TRIM_HI;
                                    n_total  = r_total - (w_hi_x - w_s_x) - W1'(1);
                                    n_state  = crs_pkg::ST_RUN;
                                end else if (w_hi_x > w_e_x) begin
                                    // last overlapping range: nothing beyond it
                                    w_cmd.op = crs_pkg::CELL_TRIM_LO;
                                    n_total  = r_total - (w_e_x - w_lo_x) - W1'(1);
                                end else begin
                                    w_cmd.op = crs_pkg::CELL_DELETE;
                                    n_count  = r_count - CNT_BITS'(1);
                                    n_total  = r_total - (w_hi_x - w_lo_x) - W1'(1);
                                    n_state  = crs_pkg::ST_RUN;
                                end
                            end
                        end
                        crs_pkg::OP_COVERS:     n_res_hit = w_cs.cov;
                        crs_pkg::OP_INTERSECTS: n_res_hit = w_cs.isect;
                        crs_pkg::OP_FIND: begin
                            if (w_cs.cont) begin
                                n_res_hit = 1'b1;
                                n_res_fs  = w_found_lo;
                                n_res_fe  = w_found_hi;
                            end
                        end
                        crs_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_total = '0;
                        end
                        default: n_res_hit = 1'b0;
                    endcase
                end
            end
            crs_pkg::ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    w_load_out = 1'b1;
                    n_state    = crs_pkg::ST_IDLE;
                end
            end
            default: n_state = crs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= crs_pkg::ST_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= i_in.op;
            r_s  <= i_in.range_start;
            r_e  <= i_in.range_end;
        end
        r_res_status <= n_res_status;
        r_res_hit    <= n_res_hit;
        r_res_fs     <= n_res_fs;
        r_res_fe     <= n_res_fe;
        if (w_load_out) begin
            r_out_status <= r_res_status;
            r_out_hit    <= r_res_hit;
            r_out_fs     <= r_res_fs;
            r_out_fe     <= r_res_fe;
            r_out_count  <= r_count;
            r_out_total  <= r_total;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.hit            = r_out_hit;
    assign o_out.found_start    = r_out_fs;
    assign o_out.found_end      = r_out_fe;
    assign o_out.ranges_held    = r_out_count;
    assign o_out.addresses_held = r_out_total;

    // A taken command always starts the sequencer
    `CRS_ASSERT_NEXT(a_accept_runs, i_clk, i_rst_n, w_accept, r_state == crs_pkg::ST_RUN)
    // The table never holds more than its capacity
    `CRS_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CNT_BITS'(MAX_RANGES))
    // A finished result reaches the output register and frees the input side
    `CRS_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, w_load_out,
                     r_out_valid && r_state == crs_pkg::ST_IDLE)
    // The reported range count never exceeds the table's capacity
    `CRS_ASSERT_NOW(a_out_cap, i_clk, i_rst_n, o_out.valid,
                    o_out.ranges_held <= CNT_BITS'(MAX_RANGES))

endmodule

@@ rtl/crs_cell.sv @@
`timescale 1ns / 1ps
// One slot of the sorted range row: holds a range, compares it with the
// current operand and shifts to/from its neighbors. Depends on crs_pkg.
module crs_cell #(
    parameter int ADDR_BITS = 32,
    parameter int CNT_BITS  = 7,
    parameter int IDX       = 0
) (
    input  logic                   i_clk,
    input  crs_pkg::t_cell_cmd     i_cmd,
    input  logic [ADDR_BITS-1:0]   i_s,
    input  logic [ADDR_BITS-1:0]   i_e,
    input  logic [CNT_BITS-1:0]    i_count,
    input  crs_pkg::t_cell_flags   i_left_flags,
    input  logic [ADDR_BITS-1:0]   i_left_lo,
    input  logic [ADDR_BITS-1:0]   i_left_hi,
    input  logic [ADDR_BITS-1:0]   i_right_lo,
    input  logic [ADDR_BITS-1:0]   i_right_hi,
    input  logic                   i_right_o_add,
    output crs_pkg::t_cell_flags   o_flags,
    output logic [ADDR_BITS-1:0]   o_lo,
    output logic [ADDR_BITS-1:0]   o_hi
);

    logic [ADDR_BITS-1:0] r_lo, r_hi, n_lo, n_hi;
    logic                 w_valid;
    logic [ADDR_BITS:0]   w_hi_p1, w_e_p1;
    crs_pkg::t_cell_flags w_f;

    assign w_valid = (CNT_BITS'(IDX) < i_count);
    assign w_hi_p1 = {1'b0, r_hi} + {{ADDR_BITS{1'b0}}, 1'b1};
    assign w_e_p1  = {1'b0, i_e} + {{ADDR_BITS{1'b0}}, 1'b1};

    always_comb begin
        w_f           = '0;
        w_f.b_add     = w_valid && (w_hi_p1 < {1'b0, i_s});
        w_f.b_rem     = w_valid && (r_hi < i_s);
        w_f.o_add     = w_valid && !w_f.b_add && !({1'b0, r_lo} > w_e_p1);
        w_f.o_rem     = w_valid && !w_f.b_rem && (r_lo <= i_e);
        w_f.first_add = w_f.o_add && !i_left_flags.o_add;
        w_f.first_rem = w_f.o_rem && !i_left_flags.o_rem;
        w_f.first_sel = i_cmd.add_mode ? w_f.first_add : w_f.first_rem;
        w_f.nxt_sel   = i_left_flags.first_sel;
        w_f.multi     = w_f.first_add && i_right_o_add;
        w_f.cov       = w_valid && (r_lo <= i_s) && (r_hi >= i_e);
        w_f.isect     = w_valid && (r_lo <= i_e) && (r_hi >= i_s);
        w_f.cont      = w_valid && (r_lo <= i_s) && (i_s <= r_hi);
    end

    assign o_flags = w_f;
    assign o_lo    = r_lo;
    assign o_hi    = r_hi;

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        unique case (i_cmd.op)
            crs_pkg::CELL_INSERT: begin
                if (!w_f.b_add) begin
                    if (i_left_flags.b_add) begin
                        n_lo = i_s;
                        n_hi = i_e;
                    end else begin
                        n_lo = i_left_lo;
                        n_hi = i_left_hi;
                    end
                end
            end
            crs_pkg::CELL_ABSORB: begin
                if (w_f.first_add) begin
                    n_hi = i_right_hi;
                end else if (!w_f.b_add) begin
                    n_lo = i_right_lo;
                    n_hi = i_right_hi;
                end
            end
            crs_pkg::CELL_MERGE: begin
                if (w_f.first_add) begin
                    n_lo = (r_lo < i_s) ? r_lo : i_s;
                    n_hi = (r_hi > i_e) ? r_hi : i_e;
                end
            end
            crs_pkg::CELL_SPLIT: begin
                if (w_f.first_rem) begin
                    n_hi = i_s - 1'b1;
                end else if (i_left_flags.first_rem) begin
                    n_lo = i_e + 1'b1;
                    n_hi = i_left_hi;
                end else if (!w_f.b_rem) begin
                    n_lo = i_left_lo;
                    n_hi = i_left_hi;
                end
            end
            crs_pkg::CELL_TRIM_HI: begin
                if (w_f.first_rem) n_hi = i_s - 1'b1;
            end
            crs_pkg::CELL_TRIM_LO: begin
                if (w_f.first_rem) n_lo = i_e + 1'b1;
            end
            crs_pkg::CELL_DELETE: begin
                if (!w_f.b_rem) begin
                    n_lo = i_right_lo;
                    n_hi = i_right_hi;
                end
            end
            default: begin
                n_lo = r_lo;
                n_hi = r_hi;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
    end

endmodule

@@ rtl/crs_chain.sv @@
`timescale 1ns / 1ps
// Row of range cells plus the OR/select reductions the sequencer reads.
// Depends on crs_pkg and crs_cell.
module crs_chain #(
    parameter int MAX_RANGES = 64,
    parameter int ADDR_BITS  = 32,
    parameter int CNT_BITS   = 7
) (
    input  logic                  i_clk,
    input  crs_pkg::t_cell_cmd    i_cmd,
    input  logic [ADDR_BITS-1:0]  i_s,
    input  logic [ADDR_BITS-1:0]  i_e,
    input  logic [CNT_BITS-1:0]   i_count,
    output crs_pkg::t_chain_status o_status,
    output logic [ADDR_BITS-1:0]  o_sel_lo,
    output logic [ADDR_BITS-1:0]  o_sel_hi,
    output logic [ADDR_BITS-1:0]  o_nxt_lo,
    output logic [ADDR_BITS-1:0]  o_found_lo,
    output logic [ADDR_BITS-1:0]  o_found_hi
);

    crs_pkg::t_cell_flags w_flags [MAX_RANGES];
    logic [ADDR_BITS-1:0] w_lo [MAX_RANGES];
    logic [ADDR_BITS-1:0] w_hi [MAX_RANGES];

    for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
        crs_pkg::t_cell_flags w_lf;
        logic [ADDR_BITS-1:0] w_llo, w_lhi, w_rlo, w_rhi;
        logic                 w_ro;

        if (k == 0) begin : g_first
            assign w_lf  = crs_pkg::CELL_EDGE_LEFT;
            assign w_llo = '0;
            assign w_lhi = '0;
        end else begin : g_mid_l
            assign w_lf  = w_flags[k-1];
            assign w_llo = w_lo[k-1];
            assign w_lhi = w_hi[k-1];
        end

        if (k == MAX_RANGES - 1) begin : g_last
            assign w_rlo = '0;
            assign w_rhi = '0;
            assign w_ro  = 1'b0;
        end else begin : g_mid_r
            assign w_rlo = w_lo[k+1];
            assign w_rhi = w_hi[k+1];
            assign w_ro  = w_flags[k+1].o_add;
        end

        crs_cell #(
            .ADDR_BITS(ADDR_BITS),
            .CNT_BITS (CNT_BITS),
            .IDX      (k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (i_cmd),
            .i_s          (i_s),
            .i_e          (i_e),
            .i_count      (i_count),
            .i_left_flags (w_lf),
            .i_left_lo    (w_llo),
            .i_left_hi    (w_lhi),
            .i_right_lo   (w_rlo),
            .i_right_hi   (w_rhi),
            .i_right_o_add(w_ro),
            .o_flags      (w_flags[k]),
            .o_lo         (w_lo[k]),
            .o_hi         (w_hi[k])
        );
    end

    // Flags are one-hot where used for selection, so AND-OR is a mux.
    always_comb begin
        o_status   = '0;
        o_sel_lo   = '0;
        o_sel_hi   = '0;
        o_nxt_lo   = '0;
        o_found_lo = '0;
        o_found_hi = '0;
        for (int k = 0; k < MAX_RANGES; k++) begin
            o_status.any_o_add |= w_flags[k].o_add;
            o_status.any_o_rem |= w_flags[k].o_rem;
            o_status.multi     |= w_flags[k].multi;
            o_status.cov       |= w_flags[k].cov;
            o_status.isect     |= w_flags[k].isect;
            o_status.cont      |= w_flags[k].cont;
            o_sel_lo   |= w_lo[k] & {ADDR_BITS{w_flags[k].first_sel}};
            o_sel_hi   |= w_hi[k] & {ADDR_BITS{w_flags[k].first_sel}};
            o_nxt_lo   |= w_lo[k] & {ADDR_BITS{w_flags[k].nxt_sel}};
            o_found_lo |= w_lo[k] & {ADDR_BITS{w_flags[k].cont}};
            o_found_hi |= w_hi[k] & {ADDR_BITS{w_flags[k].cont}};
        end
    end

endmodule
